// File: rtl/assert_macros.svh
// assertion helpers shared by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off while in reset
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/sitda_pkg.sv
package sitda_pkg;

  // input word and decimal digit geometry
  localparam int ValueBits  = 32;
  localparam int NumDigits  = 10;
  localparam int BcdBits    = 4 * NumDigits;
  localparam int BitCntW    = $clog2(ValueBits);
  localparam int DigCntW    = $clog2(NumDigits);

  // ascii codes
  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharNine  = 8'd57;

  // conversion sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } sitda_state_t;

endpackage

// File: rtl/signed_int_to_decimal_ascii_unit.sv
// channel  | ports                                 | handshake
// ---------+---------------------------------------+-------------------------------
// input    | in_value[31:0]                        | taken when start & !busy
// result   | out_character[7:0], out_last          | one beat per out_strobe pulse
//
// a number is converted by shift-and-add-3, one magnitude bit per cycle, over all
// 32 magnitude bits; then a minus sign beat when negative, then a walk over the
// 10 bcd digits, leading zeros dropped without a beat. busy stays high from accept
// until the walk ends; the next number is taken once busy is low.
// reset: synchronous, active low, returns the sequencer to idle.
// the receiver cannot stall: each beat is shown for exactly one cycle.
module signed_int_to_decimal_ascii_unit
  import sitda_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [ValueBits-1:0] in_value,
  output logic                 busy,
  output logic                 out_strobe,
  output logic [7:0]           out_character,
  output logic                 out_last
);

  sitda_state_t         state_r, state_nxt;
  logic [ValueBits-1:0] bin_r, bin_nxt;
  logic [BcdBits-1:0]   bcd_r, bcd_nxt;
  logic [BcdBits-1:0]   bcd_adj;
  logic                 neg_r, neg_nxt;
  logic                 lead_r, lead_nxt;
  logic [BitCntW-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DigCntW-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic [3:0]           top_digit;
  logic                 emit_digit;
  logic                 final_digit;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    neg_r     <= neg_nxt;
    lead_r    <= lead_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    dig_cnt_r <= dig_cnt_nxt;
  end

  // add 3 to every bcd digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  assign top_digit   = bcd_r[BcdBits-1 -: 4];
  assign final_digit = (dig_cnt_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt_r == BitCntW'(ValueBits - 1)) begin
          state_nxt = neg_r ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        state_nxt = ST_DIGITS;
      end
      ST_DIGITS: begin
        if (final_digit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy          = 1'b1;
    out_strobe    = 1'b0;
    out_character = CharZero;
    out_last      = 1'b0;
    emit_digit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_CONV: begin
      end
      ST_SIGN: begin
        out_strobe    = 1'b1;
        out_character = CharMinus;
      end
      ST_DIGITS: begin
        emit_digit    = (top_digit != 4'd0) || lead_r || final_digit;
        out_strobe    = emit_digit;
        out_character = CharZero + {4'd0, top_digit};
        out_last      = final_digit;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    neg_nxt     = neg_r;
    lead_nxt    = lead_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          // magnitude in unsigned arithmetic, most negative value included
          bin_nxt     = in_value[ValueBits-1] ? (~in_value + ValueBits'(1)) : in_value;
          neg_nxt     = in_value[ValueBits-1];
          bcd_nxt     = '0;
          lead_nxt    = 1'b0;
          bit_cnt_nxt = '0;
          dig_cnt_nxt = DigCntW'(NumDigits - 1);
        end
      end
      ST_CONV: begin
        bcd_nxt     = {bcd_adj[BcdBits-2:0], bin_r[ValueBits-1]};
        bin_nxt     = {bin_r[ValueBits-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + BitCntW'(1);
      end
      ST_SIGN: begin
      end
      ST_DIGITS: begin
        bcd_nxt     = {bcd_r[BcdBits-5:0], 4'd0};
        dig_cnt_nxt = dig_cnt_r - DigCntW'(1);
        if (emit_digit) lead_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/sitda_checker.sv
`include "assert_macros.svh"

module sitda_checker
  import sitda_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [7:0] out_character,
  input logic       out_last
);

  // a beat only comes while a number is in work
  `CHK_SAME(a_beat_while_busy, out_strobe, busy)

  // an accepted number makes the unit busy
  `CHK_NEXT(a_accept_busy, start && !busy, busy)

  // the final beat frees the unit, any other keeps it busy
  `CHK_NEXT(a_last_frees, out_strobe && out_last, !busy)
  `CHK_NEXT(a_more_follows, out_strobe && !out_last, busy)

  // only a minus sign or a decimal digit is sent
  `CHK_SAME(a_char_legal, out_strobe,
            out_character == CharMinus ||
            (out_character >= CharZero && out_character <= CharNine))

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (.*);
